[hdl/ljci_pkg.sv]
// ----------------------------------------------------------------------------
// ljci_pkg
// Shared types and constants of the leaky joint command integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package ljci_pkg;

    localparam int JOINT_COUNT = 32;
    localparam int JIDX_W      = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    // item modes
    localparam logic [1:0] MODE_INTEGRATE = 2'd0;
    localparam logic [1:0] MODE_INIT      = 2'd1;
    localparam logic [1:0] MODE_LOAD      = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [1:0] STATUS_SETUP     = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ALPHA_POS = 2'd0;
    localparam logic [1:0] CFG_ALPHA_VEL = 2'd1;
    localparam logic [1:0] CFG_STEP_TIME = 2'd2;
    localparam logic [1:0] CFG_MAX_ERR   = 2'd3;

    localparam int CFG_DATA_W = 31;

    localparam logic [16:0] ALPHA_ONE      = 17'd65536;
    localparam logic [23:0] STEP_TIME_RST  = 24'd16777;

    localparam int PROD_W = 57;
    localparam logic signed [PROD_W-1:0] RND16 = 57'sd32768;
    localparam logic signed [PROD_W-1:0] RND24 = 57'sd8388608;

    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [4:0]         joint;
        logic signed [31:0] accel_command;
        logic signed [31:0] measured_position;
        logic signed [31:0] start_position;
        logic signed [31:0] start_velocity;
        logic signed [31:0] lower_position_limit;
        logic signed [31:0] upper_position_limit;
        logic signed [31:0] lower_velocity_limit;
        logic signed [31:0] upper_velocity_limit;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         joint_echo;
        logic signed [31:0] position_command;
        logic signed [31:0] velocity_command;
        logic [1:0]         status;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] pos_floor;
        logic signed [31:0] pos_ceil;
        logic signed [31:0] vel_floor;
        logic signed [31:0] vel_ceil;
    } t_limits;

    // one step of the integrate sequence per bit
    typedef struct packed {
        logic capture;
        logic mul_vel;
        logic mul_acc;
        logic mul_pos;
        logic mul_meas;
        logic mul_dt;
        logic blend;
        logic advance;
        logic clamp_err;
        logic clamp_lim;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic integrate_go;
    } t_dp_status;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
        logic signed [31:0] r;
        if (x[32] != x[31]) begin
            r = x[32] ? MIN32 : MAX32;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // floor first, then ceiling, so a ceiling below the floor wins
    function automatic logic signed [31:0] clamp32(input logic signed [31:0] x,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        logic signed [31:0] r;
        r = (x < lo) ? lo : x;
        r = (r > hi) ? hi : r;
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/ljci_ctrl.sv]
// ----------------------------------------------------------------------------
// ljci_ctrl
// Sequencer: walks the datapath through one item and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module ljci_ctrl
    import ljci_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_DECIDE    = 11'b000_0000_0010,
        S_MUL_ACC   = 11'b000_0000_0100,
        S_MUL_POS   = 11'b000_0000_1000,
        S_MUL_MEAS  = 11'b000_0001_0000,
        S_MUL_DT    = 11'b000_0010_0000,
        S_BLEND     = 11'b000_0100_0000,
        S_ADVANCE   = 11'b000_1000_0000,
        S_CLAMP_ERR = 11'b001_0000_0000,
        S_CLAMP_LIM = 11'b010_0000_0000,
        S_DONE      = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_finish;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_finish    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.integrate_go) begin
                    o_cmd.mul_vel = 1'b1;
                    n_state       = S_MUL_ACC;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL_ACC: begin
                o_cmd.mul_acc = 1'b1;
                n_state       = S_MUL_POS;
            end
            S_MUL_POS: begin
                o_cmd.mul_pos = 1'b1;
                n_state       = S_MUL_MEAS;
            end
            S_MUL_MEAS: begin
                o_cmd.mul_meas = 1'b1;
                n_state        = S_MUL_DT;
            end
            S_MUL_DT: begin
                o_cmd.mul_dt = 1'b1;
                n_state      = S_BLEND;
            end
            S_BLEND: begin
                o_cmd.blend = 1'b1;
                n_state     = S_ADVANCE;
            end
            S_ADVANCE: begin
                o_cmd.advance = 1'b1;
                n_state       = S_CLAMP_ERR;
            end
            S_CLAMP_ERR: begin
                o_cmd.clamp_err = 1'b1;
                n_state         = S_CLAMP_LIM;
            end
            S_CLAMP_LIM: begin
                o_cmd.clamp_lim = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (w_finish) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[hdl/ljci_dp.sv]
// ----------------------------------------------------------------------------
// ljci_dp
// Datapath: joint state memories, config registers, shared multiplier,
// rounding, saturation and clamping, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ljci_dp
    import ljci_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_cfg_valid,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    output t_out_item                  o_out_item
);

    // config registers
    logic [16:0] r_alpha_pos;
    logic [16:0] r_alpha_vel;
    logic [23:0] r_step_time;
    logic [30:0] r_max_err;

    // joint state
    logic signed [31:0] mem_pos [JOINT_COUNT];
    logic signed [31:0] mem_vel [JOINT_COUNT];
    t_limits            mem_lim [JOINT_COUNT];
    logic [JOINT_COUNT-1:0] r_ready;

    t_in_item           r_item;
    logic signed [31:0] r_pos_rd;
    logic signed [31:0] r_vel_rd;
    t_limits            r_lim_rd;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [31:0]       r_v1;
    logic signed [31:0]       r_v;
    logic signed [31:0]       r_p;
    logic signed [31:0]       r_lo;
    logic signed [31:0]       r_hi;
    t_out_item                r_out;

    logic [JIDX_W-1:0]  w_idx;
    logic               w_in_range;
    logic               w_go;
    logic [16:0]        w_ap;
    logic [16:0]        w_av;
    logic signed [31:0] w_mul_a;
    logic signed [24:0] w_mul_b;
    logic signed [PROD_W-1:0] w_r16_prod;
    logic signed [PROD_W-1:0] w_r16_acc;
    logic signed [PROD_W-1:0] w_r24_prod;
    logic signed [32:0] w_v_sum;
    logic signed [32:0] w_p_sum;
    logic signed [32:0] w_lo_sum;
    logic signed [32:0] w_hi_sum;
    t_out_item          w_out;

    assign w_idx      = JIDX_W'(r_item.joint);
    assign w_in_range = (32'(r_item.joint) < JOINT_COUNT);
    assign w_go       = w_in_range && (r_item.mode == MODE_INTEGRATE) && r_ready[w_idx];
    assign o_status.integrate_go = w_go;

    // alpha above one acts as one
    assign w_ap = (r_alpha_pos > ALPHA_ONE) ? ALPHA_ONE : r_alpha_pos;
    assign w_av = (r_alpha_vel > ALPHA_ONE) ? ALPHA_ONE : r_alpha_vel;

    // shared multiplier operand select
    always_comb begin
        w_mul_a = r_item.measured_position;
        w_mul_b = $signed({8'd0, w_ap});
        if (i_cmd.mul_vel) begin
            w_mul_a = r_vel_rd;
            w_mul_b = $signed({8'd0, 17'(ALPHA_ONE - w_av)});
        end else if (i_cmd.mul_acc) begin
            w_mul_a = r_item.accel_command;
            w_mul_b = $signed({1'b0, r_step_time});
        end else if (i_cmd.mul_pos) begin
            w_mul_a = r_pos_rd;
            w_mul_b = $signed({8'd0, 17'(ALPHA_ONE - w_ap)});
        end else if (i_cmd.mul_dt) begin
            w_mul_a = r_v;
            w_mul_b = $signed({1'b0, r_step_time});
        end
    end

    // round half up, then drop the fraction bits
    assign w_r16_prod = (r_prod + RND16) >>> 16;
    assign w_r16_acc  = (r_acc + RND16) >>> 16;
    assign w_r24_prod = (r_prod + RND24) >>> 24;

    assign w_v_sum  = {r_v1[31], r_v1} + {w_r24_prod[31], w_r24_prod[31:0]};
    assign w_p_sum  = {r_p[31], r_p} + {w_r24_prod[31], w_r24_prod[31:0]};
    assign w_lo_sum = {r_item.measured_position[31], r_item.measured_position}
                      - $signed({2'b00, r_max_err});
    assign w_hi_sum = {r_item.measured_position[31], r_item.measured_position}
                      + $signed({2'b00, r_max_err});

    always_comb begin
        w_out.joint_echo       = r_item.joint;
        w_out.position_command = '0;
        w_out.velocity_command = '0;
        w_out.status           = STATUS_NOT_READY;
        if (w_go) begin
            w_out.position_command = r_p;
            w_out.velocity_command = r_v;
            w_out.status           = STATUS_OK;
        end else if (w_in_range &&
                     (r_item.mode == MODE_INIT || r_item.mode == MODE_LOAD)) begin
            w_out.status = STATUS_SETUP;
        end
    end

    assign o_out_item = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_pos <= '0;
            r_alpha_vel <= '0;
            r_step_time <= STEP_TIME_RST;
            r_max_err   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA_POS: r_alpha_pos <= i_cfg_data[16:0];
                CFG_ALPHA_VEL: r_alpha_vel <= i_cfg_data[16:0];
                CFG_STEP_TIME: r_step_time <= i_cfg_data[23:0];
                CFG_MAX_ERR:   r_max_err   <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= '0;
        end else if (i_cmd.finish && w_in_range && r_item.mode == MODE_INIT) begin
            r_ready[w_idx] <= 1'b1;
        end
    end

    // joint state memories: read at capture, written when the item finishes
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos_rd <= mem_pos[JIDX_W'(i_in_item.joint)];
            r_vel_rd <= mem_vel[JIDX_W'(i_in_item.joint)];
            r_lim_rd <= mem_lim[JIDX_W'(i_in_item.joint)];
        end
        if (i_cmd.finish && w_in_range) begin
            if (w_go) begin
                mem_pos[w_idx] <= r_p;
                mem_vel[w_idx] <= r_v;
            end else if (r_item.mode == MODE_INIT) begin
                mem_pos[w_idx] <= r_item.start_position;
                mem_vel[w_idx] <= r_item.start_velocity;
            end else if (r_item.mode == MODE_LOAD) begin
                mem_lim[w_idx] <= '{pos_floor: r_item.lower_position_limit,
                                    pos_ceil:  r_item.upper_position_limit,
                                    vel_floor: r_item.lower_velocity_limit,
                                    vel_ceil:  r_item.upper_velocity_limit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.mul_vel || i_cmd.mul_acc || i_cmd.mul_pos ||
            i_cmd.mul_meas || i_cmd.mul_dt) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (i_cmd.mul_acc) begin
            r_v1 <= w_r16_prod[31:0];
        end
        if (i_cmd.mul_pos) begin
            r_v <= sat32(w_v_sum);
        end
        if (i_cmd.mul_meas) begin
            r_acc <= r_prod;
            r_v   <= clamp32(r_v, r_lim_rd.vel_floor, r_lim_rd.vel_ceil);
        end
        if (i_cmd.mul_dt) begin
            r_acc <= r_acc + r_prod;
            r_lo  <= sat32(w_lo_sum);
            r_hi  <= sat32(w_hi_sum);
        end
        if (i_cmd.blend) begin
            r_p <= w_r16_acc[31:0];
        end
        if (i_cmd.advance) begin
            r_p <= sat32(w_p_sum);
        end
        if (i_cmd.clamp_err) begin
            r_p <= clamp32(r_p, r_lo, r_hi);
        end
        if (i_cmd.clamp_lim) begin
            r_p <= clamp32(r_p, r_lim_rd.pos_floor, r_lim_rd.pos_ceil);
        end
        if (i_cmd.finish) begin
            r_out <= w_out;
        end
    end

endmodule

`default_nettype wire

[hdl/leaky_joint_command_integrator.sv]
// ----------------------------------------------------------------------------
// leaky_joint_command_integrator
// Per-joint leaky velocity/position command integrator with clamping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one item per
//   beat: integrate, initialize joint, or load joint limits. Every item gives
//   exactly one result beat on o_out_valid / i_out_ready / o_out_item.
//   Configuration writes (i_cfg_valid / o_cfg_ready, index and data) are
//   always taken and should be made while the block is idle.
// Sequence:
//   One item is worked at a time. An integrate item runs five products
//   through one shared 32x25 multiplier followed by rounding, saturation and
//   clamp steps; set-up and error items skip these steps. The next item is
//   taken only once the result is loaded. Joint state is read on accept and
//   written back when the result is loaded.
// Reset: synchronous, active low; all joints become uninitialized and the
//   configuration returns to its defaults. No clearing pass is needed.
// Stall: a waiting result sits in the output register; the next item is
//   accepted and worked, and holds in its last step until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module leaky_joint_command_integrator
    import ljci_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    ljci_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ljci_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
